// ----- rtl/mrgp_pkg.sv -----
// shared types, constants and the golomb parameter map for the med residual block
// no dependencies
`timescale 1ns / 1ps

package mrgp_pkg;

  // field and register widths
  localparam int CFG_W      = 13;
  localparam int PIX_W      = 8;
  localparam int RES_W      = 9;
  localparam int SUM_W      = 20;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MEAN_MAX   = 255;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  // row mean divider result
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] mean;
  } div_res_t;

  // mean absolute residual to golomb parameter, floored at one
  function automatic logic [PIX_W-1:0] golomb_param(input logic [PIX_W-1:0] mean);
    return (mean == '0) ? PIX_W'(1) : mean;
  endfunction

endpackage

// ----- rtl/mrgp_div.sv -----
// restoring divider for the row mean: one quotient bit per cycle, clamped result
// depends on mrgp_pkg
`timescale 1ns / 1ps

module mrgp_div #(
  parameter int DIV_W = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mrgp_pkg::SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output mrgp_pkg::div_res_t         result
);
  import mrgp_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [DIV_W-1:0] rem_q;
  logic [SUM_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic             fits;

  // one trial subtraction per cycle
  assign shifted = {rem_q, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      quo   <= dividend;
      rem_q <= '0;
      dvs   <= divisor;
      cnt   <= CNT_W'(SUM_W);
      done  <= 1'b0;
    end else if (cnt != '0) begin
      rem_q <= fits ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
      quo   <= {quo[SUM_W-2:0], fits};
      cnt   <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  // clamp the quotient to the table range
  assign result.done = done;
  assign result.mean = (|quo[SUM_W-1:PIX_W]) ? PIX_W'(MEAN_MAX) : quo[PIX_W-1:0];

endmodule

// ----- rtl/med_residual_row_golomb_param.sv -----
// top level: med predictor residual stream with a per-row golomb parameter
// depends on mrgp_pkg and mrgp_div
//
//   channel   signals                                  direction
//   cfg       cfg_we, cfg_index, cfg_data              in, write only
//   in        in_valid, in_ready, pixel                in
//   out       out_valid, out_ready, residual,          out
//             row_end, row_param
//
// an ordinary pixel takes an accept step and then a compute step behind the
// registered line buffer read
// a pixel that closes a row also waits in a divide step for the row mean
// divider, which produces one quotient bit per cycle
// the result register frees the input side; a stalled output holds the next
// pixel in its compute or divide step until the register is taken
// reset is synchronous; the line buffer is not cleared and needs no sweep
`timescale 1ns / 1ps

module med_residual_row_golomb_param #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mrgp_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mrgp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mrgp_pkg::PIX_W-1:0]          pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mrgp_pkg::RES_W-1:0]   residual,
  output logic                                row_end,
  output logic [mrgp_pkg::PIX_W-1:0]          row_param
);
  import mrgp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV
  } state_t;

  state_t state;

  logic [CFG_W-1:0]        frame_width;
  logic [CFG_W-1:0]        frame_height;
  logic [PIX_W-1:0]        x_q;
  logic [PIX_W-1:0]        left_pixel;
  logic [PIX_W-1:0]        upper_left_pixel;
  logic [AW-1:0]           column_count;
  logic [ROW_W-1:0]        row_count;
  logic [SUM_W-1:0]        abs_sum;
  logic signed [RES_W-1:0] res_hold;

  logic [PIX_W-1:0]        line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]        rd_data;
  logic                    mem_re;
  logic                    mem_we;

  logic [WW-1:0]           fw_ext;
  logic [WW-1:0]           w_eff;
  logic [CFG_W-1:0]        h_eff;
  logic                    last;
  logic                    row_last;
  logic [PIX_W-1:0]        pred;
  logic signed [RES_W-1:0] res_val;
  logic [PIX_W-1:0]        mag;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_next;
  logic                    calc_go;
  logic                    div_start;
  logic                    out_load;
  div_res_t                div_res;

  // median edge detector over left, above and upper-left
  function automatic logic [PIX_W-1:0] med_pred(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic [PIX_W:0]   s;
    mx = (a > b) ? a : b;
    mn = (a < b) ? a : b;
    s  = {1'b0, a} + {1'b0, b} - {1'b0, c};
    if (c >= mx) return mn;
    else if (c <= mn) return mx;
    else return s[PIX_W-1:0];
  endfunction

  // effective frame size with zero and overrange handling
  assign fw_ext = WW'(frame_width);
  assign w_eff  = (frame_width == '0) ? WW'(1) :
                  (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (frame_height == '0) ? CFG_W'(1) :
                  (frame_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : frame_height;

  assign last     = (WW'(column_count) + WW'(1)) >= w_eff;
  assign row_last = (CFG_W'(row_count) + CFG_W'(1)) >= h_eff;

  // prediction by position in the frame
  always_comb begin
    if (row_count == '0) begin
      pred = (column_count == '0) ? '0 : left_pixel;
    end else if (column_count == '0) begin
      pred = rd_data;
    end else begin
      pred = med_pred(left_pixel, rd_data, upper_left_pixel);
    end
  end

  assign res_val = signed'({1'b0, x_q}) - signed'({1'b0, pred});
  assign mag     = res_val[RES_W-1] ? PIX_W'(-res_val) : PIX_W'(res_val);

  // saturating row sum of magnitudes
  assign sum_add  = {1'b0, abs_sum} + (SUM_W + 1)'(mag);
  assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  // compute step waits for the result register unless the row mean is due
  assign calc_go   = (state == S_CALC) && (last || !out_valid || out_ready);
  assign div_start = calc_go && last;
  assign in_ready  = (state == S_IDLE);
  assign mem_re    = in_valid && in_ready;
  assign mem_we    = calc_go;

  // result register takes a new item this cycle
  assign out_load = (calc_go && !last) ||
                    ((state == S_DIV) && div_res.done && (!out_valid || out_ready));

  // line buffer: read on accept, write back in the compute step
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[column_count] <= x_q;
    end
    if (mem_re) begin
      rd_data <= line_mem[column_count];
    end
  end

  mrgp_div #(
    .DIV_W (WW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (w_eff),
    .result   (div_res)
  );

  // control, context and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      column_count     <= '0;
      row_count        <= '0;
      abs_sum          <= '0;
      frame_width      <= RESET_WIDTH;
      frame_height     <= RESET_HEIGHT;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_q   <= pixel;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (calc_go) begin
            left_pixel       <= x_q;
            upper_left_pixel <= rd_data;
            if (last) begin
              abs_sum      <= '0;
              column_count <= '0;
              row_count    <= row_last ? '0 : row_count + ROW_W'(1);
              res_hold     <= res_val;
              state        <= S_DIV;
            end else begin
              abs_sum      <= sum_next;
              column_count <= column_count + AW'(1);
              out_valid    <= 1'b1;
              residual     <= res_val;
              row_end      <= 1'b0;
              row_param    <= '0;
              state        <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_res.done && (!out_valid || out_ready)) begin
            out_valid <= 1'b1;
            residual  <= res_hold;
            row_end   <= 1'b1;
            row_param <= golomb_param(div_res.mean);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mrgp_checker.sv -----
// port level checks for the med residual block, bound to the top level
// depends on mrgp_pkg and med_residual_row_golomb_param
`timescale 1ns / 1ps

module mrgp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mrgp_pkg::RES_W-1:0] residual,
  input logic                              row_end,
  input logic [mrgp_pkg::PIX_W-1:0]        row_param
);
  import mrgp_pkg::*;

  // no item leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("item offered right after reset");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(residual) && $stable(row_end)
                                && $stable(row_param))
    else $error("stalled item changed");

  // parameter only accompanies a row end
  a_param_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_end |-> row_param == '0)
    else $error("row parameter outside a row end");

  // parameter is floored at one
  a_param_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> row_param != '0)
    else $error("row parameter below one");

  // residual never reaches the most negative code
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> residual != {1'b1, {(RES_W-1){1'b0}}})
    else $error("residual out of range");

endmodule

bind med_residual_row_golomb_param mrgp_checker u_mrgp_checker (.*);
